// ===== design/poisson_count_sampler_unit_defines.svh =====
// assertion macros for the poisson count sampler
// used by design/poisson_count_sampler_unit.sv; expects clk_i and rst_ni in scope
`ifndef POISSON_COUNT_SAMPLER_UNIT_DEFINES_SVH
`define POISSON_COUNT_SAMPLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked at every edge once reset is released
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define PCS_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// ===== design/pcs_pkg.sv =====
// package for the poisson count sampler: sequencer states and fixed-point constants
// no dependencies; imported by poisson_count_sampler_unit
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  // probabilities are Q0.60
  localparam logic [60:0] ONE_Q60    = 61'h1000_0000_0000_0000;
  // floor(0.999999 * 2^60)
  localparam logic [59:0] THRESH_Q60 = 60'd1152920351685342369;
  // lambda saturation, 32.0 with 32 fraction bits
  localparam logic [37:0] LAMBDA_MAX = 38'h20_0000_0000;

  localparam int unsigned SERIES_TERMS = 20;
  localparam int unsigned SQUARINGS    = 6;

  // last step of a multiply and of a divide on the shared step counter
  localparam logic [4:0] MUL_LAST = 5'd4;
  localparam logic [4:0] DIV_LAST = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAM_MUL,
    ST_LAM_WB,
    ST_SER_MUL,
    ST_SER_DIV,
    ST_SQ_MUL,
    ST_SQ_WB,
    ST_MAIN_CHK,
    ST_MAIN_MUL,
    ST_MAIN_DIV
  } pcs_state_e;

  // product scaling of the shared multiplier
  typedef enum logic [1:0] {
    SH_0,
    SH_32,
    SH_60
  } pcs_shift_e;

endpackage

`default_nettype wire

// ===== design/poisson_count_sampler_unit.sv =====
// poisson event-count sampler, inverse-transform method, one shared 32x32 multiplier
// and one radix-16 divider by the term index; depends on pcs_pkg and the defines header
// the run time grows with m, the index of the last poisson term examined
//   (0 .. MAX_COUNT-1); the e^-lambda series (20 steps of a multiply and a divide)
//   and six squarings set the fixed part
// throughput: one transaction at a time, next input taken in the cycle its result turns valid
// reset: asynchronous active low, returns to idle with no result pending
`timescale 1ns / 1ps
`default_nettype none
`include "poisson_count_sampler_unit_defines.svh"

module poisson_count_sampler_unit #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] event_rate_i,
  input  wire logic [31:0] time_step_i,
  input  wire logic [31:0] uniform_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [6:0]       event_count_o,
  output logic             capped_o
);
  import pcs_pkg::*;

  // term index holds 0..max(MAX_COUNT, SERIES_TERMS); divisor holds 1..max(MAX_COUNT-1, 20)
  localparam int unsigned CW = ($clog2(MAX_COUNT + 1) > 5) ? $clog2(MAX_COUNT + 1) : 5;
  localparam int unsigned KW = ($clog2(MAX_COUNT) > 5) ? $clog2(MAX_COUNT) : 5;
  localparam int unsigned VW = KW + 4;

  pcs_state_e state_q, state_d;
  logic [4:0]    op_q, op_d;
  logic [CW-1:0] k_q;
  logic          out_valid_q;

  logic [31:0]  rate_q, step_q;
  logic [60:0]  u_q;
  logic [37:0]  lambda_q;
  logic [60:0]  term_q, s_q;
  logic [59:0]  sum_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;
  logic [63:0]  x_q;
  logic [KW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          capped_q;

  logic in_acc, mul_st, div_st, mul_end, div_end;
  logic chk_done, can_out, fin;

  // control strobes
  always_comb begin
    in_acc  = in_valid_i && (state_q == ST_IDLE);
    mul_st  = (state_q == ST_LAM_MUL) || (state_q == ST_SER_MUL) ||
              (state_q == ST_SQ_MUL) || (state_q == ST_MAIN_MUL);
    div_st  = (state_q == ST_SER_DIV) || (state_q == ST_MAIN_DIV);
    mul_end = mul_st && (op_q == MUL_LAST);
    div_end = div_st && (op_q == DIV_LAST);
    can_out = !out_valid_q || !out_stall_i;
    fin     = (state_q == ST_MAIN_CHK) && chk_done && can_out;
    if (mul_st || div_st) begin
      op_d = (mul_end || div_end) ? '0 : op_q + 5'd1;
    end else begin
      op_d = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_LAM_MUL;
      ST_LAM_MUL:  if (mul_end) state_d = ST_LAM_WB;
      ST_LAM_WB:   state_d = ST_SER_MUL;
      ST_SER_MUL:  if (mul_end) state_d = ST_SER_DIV;
      ST_SER_DIV: begin
        if (div_end) begin
          state_d = (k_q == CW'(SERIES_TERMS)) ? ST_SQ_MUL : ST_SER_MUL;
        end
      end
      ST_SQ_MUL:   if (mul_end) state_d = ST_SQ_WB;
      ST_SQ_WB:    state_d = (k_q == CW'(SQUARINGS - 1)) ? ST_MAIN_CHK : ST_SQ_MUL;
      ST_MAIN_CHK: begin
        if (!chk_done) begin
          state_d = ST_MAIN_MUL;
        end else if (can_out) begin
          state_d = ST_IDLE;
        end
      end
      ST_MAIN_MUL: if (mul_end) state_d = ST_MAIN_DIV;
      ST_MAIN_DIV: if (div_end) state_d = ST_MAIN_CHK;
      default:     state_d = ST_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = out_valid_q;
    event_count_o = 7'(cnt_q);
    capped_o      = capped_q;
  end

  // shared multiplier operands and product scaling
  logic [63:0]  mul_a, mul_b;
  logic [31:0]  limb_a, limb_b;
  logic [127:0] acc_add;
  pcs_shift_e   sh_sel;
  logic [63:0]  mres;

  always_comb begin
    unique case (state_q)
      ST_LAM_MUL: begin
        mul_a = {32'd0, rate_q};
        mul_b = {32'd0, step_q};
      end
      ST_SER_MUL: begin
        mul_a = {3'd0, term_q};
        mul_b = {4'd0, lambda_q, 22'd0};
      end
      ST_SQ_MUL: begin
        mul_a = {3'd0, s_q};
        mul_b = {3'd0, s_q};
      end
      default: begin
        mul_a = {3'd0, term_q};
        mul_b = {26'd0, lambda_q};
      end
    endcase
    case (op_q)
      5'd0:    begin limb_a = mul_a[31:0];  limb_b = mul_b[31:0];  end
      5'd1:    begin limb_a = mul_a[31:0];  limb_b = mul_b[63:32]; end
      5'd2:    begin limb_a = mul_a[63:32]; limb_b = mul_b[31:0];  end
      default: begin limb_a = mul_a[63:32]; limb_b = mul_b[63:32]; end
    endcase
    // partial product registered last step lands at its weight now
    case (op_q) inside
      5'd1:       acc_add = {64'd0, pp_q};
      5'd2, 5'd3: acc_add = {32'd0, pp_q, 32'd0};
      default:    acc_add = {pp_q, 64'd0};
    endcase
  end

  // scaled and saturated product
  always_comb begin
    unique case (state_q)
      ST_LAM_WB:   sh_sel = SH_0;
      ST_MAIN_DIV: sh_sel = SH_32;
      default:     sh_sel = SH_60;
    endcase
    case (sh_sel)
      SH_0:    mres = acc_q[63:0];
      SH_32:   mres = (acc_q[127:96] != '0) ? '1 : acc_q[95:32];
      default: mres = (acc_q[127:124] != '0) ? '1 : acc_q[123:60];
    endcase
  end

  // radix-16 divider step, remainder stays below the divisor
  logic [KW-1:0] divisor;
  logic [VW-1:0] div_v, rem_full;
  logic [3:0]    digit;
  logic [63:0]   x_d;

  always_comb begin
    divisor = k_q[KW-1:0];
    div_v   = {rem_q, x_q[63:60]};
    digit   = '0;
    for (int j = 1; j < 16; j++) begin
      if (div_v >= VW'(VW'(j) * VW'(divisor))) digit = 4'(j);
    end
    rem_full = div_v - VW'(VW'(digit) * VW'(divisor));
    x_d      = {x_q[59:0], digit};
  end

  // cumulative sum check
  logic [37:0]   lam_d;
  logic [60:0]   sum_n;
  logic          sum_gt, sum_thr, at_cap;
  logic [CW-1:0] res_cnt;
  logic          res_cap;

  always_comb begin
    lam_d   = (acc_q[63:0] > {26'd0, LAMBDA_MAX}) ? LAMBDA_MAX : acc_q[37:0];
    sum_n   = {1'b0, sum_q} + term_q;
    sum_gt  = sum_n > u_q;
    sum_thr = sum_n >= {1'b0, THRESH_Q60};
    at_cap  = (k_q == CW'(MAX_COUNT - 1));
    chk_done = sum_gt || sum_thr || at_cap;
    res_cap = 1'b0;
    if (sum_gt) begin
      res_cnt = k_q;
    end else if (sum_thr) begin
      res_cnt = k_q + 1'b1;
    end else begin
      res_cnt = CW'(MAX_COUNT);
      res_cap = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LAM_WB: k_q <= CW'(1);
        ST_SER_DIV: begin
          if (div_end) k_q <= (k_q == CW'(SERIES_TERMS)) ? '0 : k_q + 1'b1;
        end
        ST_SQ_WB: k_q <= (k_q == CW'(SQUARINGS - 1)) ? '0 : k_q + 1'b1;
        ST_MAIN_CHK: if (!chk_done) k_q <= k_q + 1'b1;
        default: k_q <= k_q;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rate_q <= event_rate_i;
      step_q <= time_step_i;
      u_q    <= (uniform_i == '1) ? ONE_Q60 : {1'b0, uniform_i, 28'd0};
    end
    if (mul_st) begin
      pp_q  <= limb_a * limb_b;
      acc_q <= (op_q == '0) ? '0 : acc_q + acc_add;
    end
    if (div_st) begin
      if (op_q == '0) begin
        x_q   <= mres;
        rem_q <= '0;
      end else begin
        x_q   <= x_d;
        rem_q <= rem_full[KW-1:0];
      end
    end
    if (div_end) term_q <= x_d[60:0];
    // alternating series for e^-(lambda/64)
    if (div_end && (state_q == ST_SER_DIV)) begin
      if (k_q[0]) begin
        s_q <= (s_q >= x_d[60:0]) ? s_q - x_d[60:0] : '0;
      end else begin
        s_q <= s_q + x_d[60:0];
      end
    end
    if (state_q == ST_LAM_WB) begin
      lambda_q <= lam_d;
      term_q   <= ONE_Q60;
      s_q      <= ONE_Q60;
      sum_q    <= '0;
    end
    if (state_q == ST_SQ_WB) begin
      s_q <= mres[60:0];
      if (k_q == CW'(SQUARINGS - 1)) term_q <= mres[60:0];
    end
    if ((state_q == ST_MAIN_CHK) && !chk_done) sum_q <= sum_n[59:0];
    if (fin) begin
      cnt_q    <= res_cnt;
      capped_q <= res_cap;
    end
  end

  `PCS_ASSERT(a_cap_full, out_valid_o && capped_o |-> event_count_o == 7'(MAX_COUNT), "capped result without full count")
  `PCS_ASSERT(a_accept_start, in_valid_i && !in_stall_o |=> state_q == ST_LAM_MUL && op_q == '0, "transaction did not start lambda multiply")
  `PCS_ASSERT_ALL(a_div_rem, div_st && op_q != '0 |-> rem_q < divisor && divisor != '0, "divider remainder out of range")
  `PCS_ASSERT(a_k_range, state_q == ST_MAIN_CHK |-> k_q < CW'(MAX_COUNT), "term index beyond count limit")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for poisson_count_sampler_unit: directed and random draws
// against a bit-exact fixed-point predictor; depends on pcs_pkg and the design top
`timescale 1ns / 1ps

module testbench;
  import pcs_pkg::*;

  localparam int unsigned MAX_COUNT  = 64;
  // cycles with no transaction on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 20000;
  // covers the longest single computation, with margin
  localparam int unsigned DRAIN_CYCLES = 2500;
  localparam int unsigned IDLE_PCT = 17;

  typedef struct packed {
    logic [31:0] rate;
    logic [31:0] step;
    logic [31:0] uniform;
  } draw_t;

  typedef struct packed {
    logic [6:0] count;
    logic       capped;
  } sample_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] event_rate = '0;
  logic [31:0] time_step = '0;
  logic [31:0] uniform = '0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [6:0]  event_count_o;
  logic        capped_o;

  draw_t       draws_q[$];
  sample_t     sampled_counts_q[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  wire in_fire  = in_valid && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall;

  poisson_count_sampler_unit #(
    .MAX_COUNT(MAX_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .event_rate_i (event_rate),
    .time_step_i  (time_step),
    .uniform_i    (uniform),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .event_count_o(event_count_o),
    .capped_o     (capped_o)
  );

  // append to the pending draws
  function automatic void queue_draw(input draw_t d);
    draws_q = {draws_q, d};
  endfunction

  // append to the expected results
  function automatic void queue_expected(input sample_t s);
    sampled_counts_q = {sampled_counts_q, s};
  endfunction

  // floor(a * b / 2^sh), saturating at all ones
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int unsigned sh);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p >> sh;
    if (p[127:64] != '0) return '1;
    return p[63:0];
  endfunction

  // e^-lambda in Q0.60: taylor series at lambda/64, then squared six times
  function automatic logic [63:0] exp_neg_q60(input logic [63:0] lam);
    logic [63:0] y, s, t;
    int unsigned k;
    y = lam << 22;
    s = ONE_Q60;
    t = ONE_Q60;
    for (k = 1; k <= SERIES_TERMS; k++) begin
      t = scaled_product(t, y, 60) / k;
      if ((k % 2) == 1) s = (s >= t) ? s - t : '0;
      else s = s + t;
    end
    for (k = 0; k < SQUARINGS; k++) s = scaled_product(s, s, 60);
    return s;
  endfunction

  // inverse-transform walk over the poisson terms
  function automatic sample_t sample_event_count(input draw_t d);
    logic [63:0] lam, u, term, total;
    int unsigned k, cnt;
    logic        done;
    sample_t     r;
    lam = {32'b0, d.rate} * {32'b0, d.step};
    if (lam > LAMBDA_MAX) lam = LAMBDA_MAX;
    if (d.uniform == '1) u = ONE_Q60;
    else u = {4'b0, d.uniform, 28'b0};
    term = exp_neg_q60(lam);
    total = '0;
    cnt = MAX_COUNT;
    r.capped = 1'b1;
    done = 1'b0;
    for (k = 0; k < MAX_COUNT && !done; k++) begin
      if (k > 0) term = scaled_product(term, lam, 32) / k;
      total = total + term;
      if (total > u) begin
        cnt = k;
        r.capped = 1'b0;
        done = 1'b1;
      end else if (total >= THRESH_Q60) begin
        cnt = k + 1;
        r.capped = 1'b0;
        done = 1'b1;
      end
    end
    r.count = cnt[6:0];
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // reset, asserted at time zero and released on a clock edge
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // input driver: records the prediction of each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive_inputs
    draw_t       nxt;
    int unsigned sent;
    int unsigned pct;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      sent = 0;
    end else begin
      if (in_fire) begin
        nxt = '{event_rate, time_step, uniform};
        queue_expected(sample_event_count(nxt));
        sent++;
      end
      if (!in_valid || !in_stall_o) begin
        // a long stretch with no input gaps
        pct = (sent >= 700 && sent < 1000) ? 0 : IDLE_PCT;
        if (draws_q.size() != 0 && $urandom_range(0, 99) >= pct) begin
          nxt = draws_q.pop_front();
          in_valid   <= 1'b1;
          event_rate <= nxt.rate;
          time_step  <= nxt.step;
          uniform    <= nxt.uniform;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    sample_t     want;
    int unsigned received;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      received = 0;
    end else begin
      if (out_fire) begin
        if (sampled_counts_q.size() == 0) begin
          $display("%0t: result with nothing expected: event_count %0d capped %0b",
                   $time, event_count_o, capped_o);
          errors++;
        end else begin
          want = sampled_counts_q.pop_front();
          if (event_count_o !== want.count) begin
            $display("%0t: event_count expected %0d actual %0d",
                     $time, want.count, event_count_o);
            errors++;
          end
          if (capped_o !== want.capped) begin
            $display("%0t: capped expected %0b actual %0b", $time, want.capped, capped_o);
            errors++;
          end
        end
        received++;
      end
      // no stalls over a long stretch of results
      if (received >= 700 && received < 1000) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    draw_t       d;
    int unsigned pick, upick, sa, sb, n;

    // zero lambda, both uniform extremes and a midpoint
    queue_draw('{32'h0000_0000, 32'h0001_0000, 32'h0000_0000});
    queue_draw('{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF});
    queue_draw('{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    queue_draw('{32'h0001_0000, 32'h0000_0000, 32'h8000_0000});
    // smallest nonzero lambda
    queue_draw('{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFE});
    queue_draw('{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF});
    // lambda of one
    queue_draw('{32'h0001_0000, 32'h0001_0000, 32'h0000_0000});
    queue_draw('{32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF});
    queue_draw('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_EF00});
    queue_draw('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF});
    // lambda exactly at, just below and just above saturation
    queue_draw('{32'h0020_0000, 32'h0001_0000, 32'h5555_5555});
    queue_draw('{32'h0020_0000, 32'h0001_0000, 32'hFFFF_FFFF});
    queue_draw('{32'h001F_FFFF, 32'h0001_0000, 32'hFFFF_FFFF});
    queue_draw('{32'h0020_0001, 32'h0001_0000, 32'hAAAA_AAAA});
    // full-scale inputs, saturated lambda
    queue_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});
    queue_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000});
    queue_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE});
    queue_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    queue_draw('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0});
    // moderate lambda with uniform near one
    queue_draw('{32'h0008_0000, 32'h0001_0000, 32'hFFFF_FFFF});

    // random draws, most with lambda well inside range to keep the walk short
    for (n = 0; n < 1700; n++) begin
      pick = $urandom_range(0, 99);
      sa = $urandom_range(0, 27);
      sb = 27 - sa + $urandom_range(0, 6);
      if (pick < 12) begin
        d.rate = $urandom;
        d.step = $urandom;
      end else if (pick < 16) begin
        d.rate = (pick % 2 == 1) ? 32'h0 : $urandom;
        d.step = (pick % 2 == 1) ? $urandom : 32'h0;
      end else begin
        d.rate = $urandom >> sa;
        d.step = $urandom >> sb;
      end
      upick = $urandom_range(0, 99);
      if (upick < 85) d.uniform = $urandom;
      else if (upick < 89) d.uniform = 32'hFFFF_FFFF;
      else if (upick < 92) d.uniform = 32'h0;
      else if (upick < 95) d.uniform = 32'hFFFF_FFFE;
      else d.uniform = $urandom_range(32'hFFFF_C000, 32'hFFFF_FFFF);
      queue_draw(d);
    end

    @(posedge rst_ni);
    while (draws_q.size() != 0 || in_valid || sampled_counts_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pcs_pkg.sv
design/poisson_count_sampler_unit.sv
bench/testbench.sv
